// File: src/ual_pkg.sv
// Package: shared constants, command codes and transaction types for the array list core.
`default_nettype none
package ual_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Command codes
  localparam logic [2:0] CMD_INSERT     = 3'd0;
  localparam logic [2:0] CMD_REMOVE     = 3'd1;
  localparam logic [2:0] CMD_REMOVE_ODD = 3'd2;
  localparam logic [2:0] CMD_SORT       = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [4:0]         position;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [5:0]         count;
    logic               is_empty;
    logic               is_full;
    logic signed [31:0] smallest;
  } out_t;

  // Result handoff from the sequencer to the output stage
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage
`default_nettype wire

// File: src/unordered_array_list_core.sv
// Top level: bounded unsorted list of signed words with an iterative sequencer.
// Each command ends with a walk over the entries for the smallest value; sort first runs
// bubble passes and remove/remove-odd first compact the list. Output stalls hold results.
// Throughput: one transaction at a time; the next is taken the cycle after the result is
// loaded, set by the walks over the single-read-port entry RAM.
// Reset clears the count, the sequencer state and the output valid flag.
`default_nettype none
module unordered_array_list_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ual_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ual_pkg::out_t      out_data
);

  logic                                ctrl_idle;
  logic                                res_ready;
  ual_pkg::res_t                       ctrl_res;
  logic                                ram_we;
  logic [ual_pkg::IDX_W-1:0]           ram_waddr;
  logic [ual_pkg::DATA_W-1:0]          ram_wdata;
  logic [ual_pkg::IDX_W-1:0]           ram_raddr;
  logic [ual_pkg::DATA_W-1:0]          ram_rdata;
  logic signed [ual_pkg::DATA_W-1:0]   cmp_a;
  logic signed [ual_pkg::DATA_W-1:0]   cmp_b;
  logic                                cmp_lt;
  logic                                cmp_eq;

  assign in_stall  = !ctrl_idle;
  assign res_ready = !out_valid || !out_stall;

  ual_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && !in_stall),
    .cmd_in    (in_data),
    .idle      (ctrl_idle),
    .res_ready (res_ready),
    .res       (ctrl_res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .cmp_a     (cmp_a),
    .cmp_b     (cmp_b),
    .cmp_lt    (cmp_lt),
    .cmp_eq    (cmp_eq)
  );

  ual_ram #(
    .WIDTH (ual_pkg::DATA_W),
    .DEPTH (ual_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ual_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt),
    .eq (cmp_eq)
  );

  // Output register: holds a result while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl_res.valid && res_ready) begin
      out_valid <= 1'b1;
      out_data  <= ctrl_res.data;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: src/ual_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ual_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/ual_cmp.sv
// Shared compare unit: signed less-than and equality of two words.
`default_nettype none
module ual_cmp (
  input  wire logic signed [ual_pkg::DATA_W-1:0] a,
  input  wire logic signed [ual_pkg::DATA_W-1:0] b,
  output logic                                   lt,
  output logic                                   eq
);

  assign lt = (a < b);
  assign eq = (a == b);

endmodule
`default_nettype wire

// File: src/ual_ctrl.sv
// Sequencer: walks the entry RAM through the shared compare unit for every command.
`default_nettype none
module ual_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire ual_pkg::in_t                        cmd_in,
  output logic                                     idle,
  input  wire logic                                res_ready,
  output ual_pkg::res_t                            res,
  // RAM port
  output logic                                     ram_we,
  output logic [ual_pkg::IDX_W-1:0]                ram_waddr,
  output logic [ual_pkg::DATA_W-1:0]               ram_wdata,
  output logic [ual_pkg::IDX_W-1:0]                ram_raddr,
  input  wire logic [ual_pkg::DATA_W-1:0]          ram_rdata,
  // Compare unit
  output logic signed [ual_pkg::DATA_W-1:0]        cmp_a,
  output logic signed [ual_pkg::DATA_W-1:0]        cmp_b,
  input  wire logic                                cmp_lt,
  input  wire logic                                cmp_eq
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_COMPACT,
    S_SORT,
    S_TAIL,
    S_RDA,
    S_RDB,
    S_MIN,
    S_DONE
  } state_t;

  localparam logic [ual_pkg::CNT_W-1:0] CAP = ual_pkg::CNT_W'(ual_pkg::CAPACITY);

  state_t                           state;
  logic [2:0]                       cmd;
  logic signed [ual_pkg::DATA_W-1:0] val;
  logic [4:0]                       pos;
  logic [ual_pkg::CNT_W-1:0]        used;
  logic [ual_pkg::CNT_W-1:0]        rptr;
  logic [ual_pkg::CNT_W-1:0]        rend;
  logic                             dvalid;
  logic [ual_pkg::IDX_W-1:0]        didx;
  logic [ual_pkg::CNT_W-1:0]        kept;
  logic                             found;
  logic signed [ual_pkg::DATA_W-1:0] carry;
  logic [ual_pkg::CNT_W-1:0]        lim;
  logic signed [ual_pkg::DATA_W-1:0] minv;
  logic                             ok;
  logic signed [ual_pkg::DATA_W-1:0] rdval;

  logic issue;
  logic drop;
  logic signed [ual_pkg::DATA_W-1:0] rdata_s;

  assign rdata_s = ram_rdata;
  assign cmp_a   = rdata_s;
  assign idle    = (state == S_IDLE);

  // Entry to discard during compaction: first match, or any odd value
  assign drop = (cmd == ual_pkg::CMD_REMOVE) ? (!found && cmp_eq) : ram_rdata[0];

  // RAM addressing, write data and compare operand selection
  always_comb begin
    issue     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_raddr = rptr[ual_pkg::IDX_W-1:0];
    cmp_b     = minv;
    case (state)
      S_INS: begin
        ram_we    = (used < CAP);
        ram_waddr = used[ual_pkg::IDX_W-1:0];
        ram_wdata = val;
      end
      S_COMPACT: begin
        issue     = (rptr < rend);
        cmp_b     = val;
        ram_we    = dvalid && !drop;
        ram_waddr = kept[ual_pkg::IDX_W-1:0];
      end
      S_SORT: begin
        issue     = (rptr < rend);
        cmp_b     = carry;
        ram_we    = dvalid && (didx != '0);
        ram_waddr = ual_pkg::IDX_W'(didx - 1'b1);
        ram_wdata = cmp_lt ? rdata_s : carry;
      end
      S_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = lim[ual_pkg::IDX_W-1:0];
        ram_wdata = carry;
      end
      S_RDA: begin
        ram_raddr = ual_pkg::IDX_W'(pos);
      end
      S_MIN: begin
        issue = (rptr < rend);
        cmp_b = minv;
      end
      default: begin
      end
    endcase
  end

  // Result fields straight from state registers
  always_comb begin
    res.valid           = (state == S_DONE);
    res.data.ok         = ok;
    res.data.read_value = rdval;
    res.data.count      = 6'(used);
    res.data.is_empty   = (used == '0);
    res.data.is_full    = (used == CAP);
    res.data.smallest   = minv;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      used   <= '0;
      dvalid <= 1'b0;
    end else begin
      dvalid <= issue;
      didx   <= rptr[ual_pkg::IDX_W-1:0];
      if (issue) begin
        rptr <= rptr + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd   <= cmd_in.command;
            val   <= cmd_in.value;
            pos   <= cmd_in.position;
            ok    <= 1'b0;
            rdval <= '0;
            rptr  <= '0;
            rend  <= used;
            kept  <= '0;
            found <= 1'b0;
            lim   <= used - 1'b1;
            case (cmd_in.command)
              ual_pkg::CMD_INSERT: state <= S_INS;
              ual_pkg::CMD_REMOVE,
              ual_pkg::CMD_REMOVE_ODD: state <= (used == '0) ? S_MIN : S_COMPACT;
              ual_pkg::CMD_SORT: begin
                ok    <= (used != '0);
                state <= (used > 1) ? S_SORT : S_MIN;
              end
              ual_pkg::CMD_READ: state <= S_RDA;
              default: state <= S_MIN;
            endcase
          end
        end
        S_INS: begin
          rptr <= '0;
          if (used < CAP) begin
            used <= used + 1'b1;
            rend <= used + 1'b1;
            ok   <= 1'b1;
          end
          state <= S_MIN;
        end
        S_COMPACT: begin
          if (dvalid) begin
            if (!drop) begin
              kept <= kept + 1'b1;
            end
            if ((cmd == ual_pkg::CMD_REMOVE) && !found && cmp_eq) begin
              found <= 1'b1;
            end
          end
          if (!issue && !dvalid) begin
            used  <= kept;
            ok    <= (cmd == ual_pkg::CMD_REMOVE) ? found : 1'b1;
            rptr  <= '0;
            rend  <= kept;
            state <= S_MIN;
          end
        end
        S_SORT: begin
          // carry holds the largest value seen so far in this pass
          if (dvalid) begin
            if (didx == '0 || !cmp_lt) begin
              carry <= rdata_s;
            end
          end
          if (!issue && !dvalid) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          rptr <= '0;
          if (lim == 1) begin
            rend  <= used;
            state <= S_MIN;
          end else begin
            lim   <= lim - 1'b1;
            rend  <= lim;
            state <= S_SORT;
          end
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          if (32'(pos) < 32'(used)) begin
            ok    <= 1'b1;
            rdval <= rdata_s;
          end
          rptr  <= '0;
          rend  <= used;
          state <= S_MIN;
        end
        S_MIN: begin
          if (dvalid && (didx == '0 || cmp_lt)) begin
            minv <= rdata_s;
          end
          if (!issue && !dvalid) begin
            if (used == '0) begin
              minv <= '0;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Count never exceeds capacity
  a_used_bound: assert property (@(posedge clk) disable iff (rst) used <= CAP)
    else $error("entry count above capacity");

  // Compaction never writes ahead of the entry being read
  a_kept_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPACT && dvalid) |-> (32'(kept) <= 32'(didx)))
    else $error("compaction write overtook read");

  // A sort pass limit stays inside the list
  a_sort_lim: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT || state == S_TAIL) |-> (lim < used && lim != '0))
    else $error("sort pass limit out of range");

  // A finished result is held until the output stage takes it
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res_ready) |=> (res.valid && $stable(res.data)))
    else $error("result dropped before handoff");

  // New transactions start only from idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> idle)
    else $error("transaction started while busy");

endmodule
`default_nettype wire
